// ===== sv/rmsd_pkg.sv =====
// Shared types and constants for the running mean / standard deviation block.
// Holds the field widths, the item kind and error codes and the sequencer states.
// No dependencies.
package rmsd_pkg;

    // Defaults of the top-level parameters
    localparam int SCORE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Port field widths
    localparam int KIND_W     = 2;
    localparam int SCORE_W    = 10;
    localparam int COUNT_W    = 16;
    localparam int STAT_W     = 18;
    localparam int ERR_W      = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;
    localparam int OUT_PAD_W  = M_TDATA_W - COUNT_W - 2 * STAT_W;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_DIV,
        ST_SS_MUL,
        ST_NQ_MUL,
        ST_NN_MUL,
        ST_SD_DIV,
        ST_SQRT,
        ST_FINISH
    } state_t;

endpackage

// ===== sv/running_mean_stddev_add_remove.sv =====
// Running count, mean and population standard deviation of a multiset of scores.
// Uses rmsd_pkg for widths, codes and the sequencer state type.
//
// s_axis: one transaction per item; tuser carries the kind (add, remove, clear),
//   tdata the score. m_axis: one transaction per input item, in order; tdata carries
//   the count, the mean and the standard deviation (FRAC_BITS fraction bits, truncated,
//   saturated at the field maximum), tuser the error code (remove while empty, add
//   while full; the state is left unchanged in both cases).
// The mean and deviation arithmetic runs on one shared add/subtract unit under a
//   sequencer: the item is accepted, then a restoring divide for the mean,
//   shift-add products S*S, n*Q and n*n, a restoring divide of (n*Q-S*S)<<2F by
//   n*n and a bit-pair square root, then the result is handed off. The sequence
//   ends early when n*Q is below S*S, when the variance saturates or with one
//   score held (after the mean); with no scores held it goes straight to the
//   hand-off. s_axis_tready is high only while the sequencer is idle, so a new
//   item is not taken until the last one has been handed off.
// Reset clears the count and both sums. The result sits in an output register;
//   a new item is taken while it waits, and the sequencer holds in its last
//   state until the receiver frees the output register.
module running_mean_stddev_add_remove #(
    parameter int SCORE_BITS = rmsd_pkg::SCORE_BITS_DEF,
    parameter int COUNT_BITS = rmsd_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = rmsd_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rmsd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [9:0] score, [15:10] zero
    input  logic [rmsd_pkg::KIND_W-1:0]    s_axis_tuser,  // [1:0] kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] item_count, [33:16] mean_q8, [51:34] stddev_q8, [55:52] zero
    output logic [rmsd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [rmsd_pkg::ERR_W-1:0]     m_axis_tuser   // [1:0] error
);

    localparam int STAT_W   = rmsd_pkg::STAT_W;
    localparam int SUM_BITS = SCORE_BITS + COUNT_BITS;
    localparam int SQ_BITS  = 2 * SCORE_BITS + COUNT_BITS + 1;
    localparam int SQ2_BITS = 2 * SCORE_BITS;
    // width of n*Q - S*S
    localparam int PW       = SQ_BITS + COUNT_BITS;
    // square root input width
    localparam int QW       = 2 * STAT_W;
    // shared unit and accumulator width (one extra bit for the sign of n*Q-S*S)
    localparam int UW       = (PW + 1 > QW + 1) ? PW + 1 : QW + 1;
    // mean dividend bits, deviation dividend bits
    localparam int DW_MEAN  = SUM_BITS + FRAC_BITS;
    localparam int DW_SD    = PW + 2 * FRAC_BITS;
    // dividend shift register, also holds the root bit
    localparam int BW       = (DW_SD > QW) ? DW_SD : QW;
    // divisor width (n*n)
    localparam int RW       = 2 * COUNT_BITS;
    localparam int MPW      = SUM_BITS;
    localparam int CNT_W    = $clog2(BW + 1);

    localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

    // Sequencer and statistics state
    rmsd_pkg::state_t          state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic [SUM_BITS-1:0]       sum_reg, sum_next;
    logic [SQ_BITS-1:0]        sq_reg, sq_next;
    logic                      out_valid_reg, out_valid_next;

    // Datapath registers
    logic [UW-1:0]             acc_reg, acc_next;
    logic [UW-1:0]             mc_reg, mc_next;
    logic [MPW-1:0]            mp_reg, mp_next;
    logic [BW-1:0]             b_reg, b_next;
    logic [RW-1:0]             d_reg, d_next;
    logic [QW-1:0]             q_reg, q_next;
    logic                      ovf_reg, ovf_next;
    logic [STAT_W-1:0]         mean_reg, mean_next;
    logic [STAT_W-1:0]         sd_reg, sd_next;
    logic [rmsd_pkg::ERR_W-1:0] err_reg, err_next;

    // Output register
    logic [rmsd_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [STAT_W-1:0]            out_mean_reg, out_mean_next;
    logic [STAT_W-1:0]            out_sd_reg, out_sd_next;
    logic [rmsd_pkg::ERR_W-1:0]   out_err_reg, out_err_next;

    // Shared add/subtract unit
    logic [UW-1:0]             au_a, au_b;
    logic                      au_sub;
    logic [UW:0]               au_res;
    logic                      au_ge;

    // Step helpers
    logic [RW:0]               div_shift;
    logic [UW-1:0]             div_rem;
    logic [UW-1:0]             mul_acc;
    logic [QW-1:0]             q_step;
    logic                      ovf_step;
    logic                      last_step;
    logic [UW-1:0]             root_step;

    // Input decode and state update
    logic                      in_fire;
    logic [SCORE_BITS-1:0]     score_in;
    logic [SQ2_BITS-1:0]       score_sq;
    logic [COUNT_BITS-1:0]     upd_count;
    logic [SUM_BITS-1:0]       upd_sum;
    logic [SQ_BITS-1:0]        upd_sq;
    logic [rmsd_pkg::ERR_W-1:0] upd_err;

    assign s_axis_tready = (state_reg == rmsd_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign score_in      = SCORE_BITS'(s_axis_tdata[rmsd_pkg::SCORE_W-1:0]);
    assign score_sq      = SQ2_BITS'(score_in) * SQ2_BITS'(score_in);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{rmsd_pkg::OUT_PAD_W{1'b0}}, out_sd_reg, out_mean_reg, out_count_reg};
    assign m_axis_tuser  = out_err_reg;

    // Apply the item to count, sum and square sum
    always_comb
    begin
        upd_count = count_reg;
        upd_sum   = sum_reg;
        upd_sq    = sq_reg;
        upd_err   = rmsd_pkg::ERR_OK;
        unique case (s_axis_tuser)
            rmsd_pkg::KIND_ADD:
            begin
                if (count_reg == {COUNT_BITS{1'b1}})
                begin
                    upd_err = rmsd_pkg::ERR_FULL;
                end
                else
                begin
                    upd_count = count_reg + COUNT_BITS'(1);
                    upd_sum   = sum_reg + SUM_BITS'(score_in);
                    upd_sq    = sq_reg + SQ_BITS'(score_sq);
                end
            end
            rmsd_pkg::KIND_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    upd_err = rmsd_pkg::ERR_EMPTY;
                end
                else if (count_reg == COUNT_BITS'(1))
                begin
                    // last score gone: drop whatever the sums hold
                    upd_count = '0;
                    upd_sum   = '0;
                    upd_sq    = '0;
                end
                else
                begin
                    upd_count = count_reg - COUNT_BITS'(1);
                    upd_sum   = sum_reg - SUM_BITS'(score_in);
                    upd_sq    = sq_reg - SQ_BITS'(score_sq);
                end
            end
            rmsd_pkg::KIND_CLEAR:
            begin
                upd_count = '0;
                upd_sum   = '0;
                upd_sq    = '0;
            end
            default:
            begin
                upd_err = rmsd_pkg::ERR_OK;
            end
        endcase
    end

    // Operand selection for the shared unit
    always_comb
    begin
        au_a   = acc_reg;
        au_b   = mc_reg;
        au_sub = 1'b0;
        unique case (state_reg)
            rmsd_pkg::ST_MEAN_DIV, rmsd_pkg::ST_SD_DIV:
            begin
                au_a   = UW'(div_shift);
                au_b   = UW'(d_reg);
                au_sub = 1'b1;
            end
            rmsd_pkg::ST_SS_MUL:
            begin
                // accumulate -S*S so that n*Q lands on the difference
                au_sub = 1'b1;
            end
            rmsd_pkg::ST_SQRT:
            begin
                au_b   = mc_reg | UW'(b_reg);
                au_sub = 1'b1;
            end
            default:
            begin
                au_sub = 1'b0;
            end
        endcase
    end

    assign au_res    = au_sub ? ({1'b0, au_a} - {1'b0, au_b}) : ({1'b0, au_a} + {1'b0, au_b});
    assign au_ge     = ~au_res[UW];

    assign div_shift = {acc_reg[RW-1:0], b_reg[BW-1]};
    assign div_rem   = au_ge ? au_res[UW-1:0] : UW'(div_shift);
    assign mul_acc   = mp_reg[0] ? au_res[UW-1:0] : acc_reg;
    assign q_step    = {q_reg[QW-2:0], au_ge};
    assign ovf_step  = ovf_reg | q_reg[QW-1];
    assign last_step = (cnt_reg == CNT_W'(1));
    assign root_step = au_ge ? ((mc_reg >> 1) | UW'(b_reg)) : (mc_reg >> 1);

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        mc_next        = mc_reg;
        mp_next        = mp_reg;
        b_next         = b_reg;
        d_next         = d_reg;
        q_next         = q_reg;
        ovf_next       = ovf_reg;
        mean_next      = mean_reg;
        sd_next        = sd_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_count_next = out_count_reg;
        out_mean_next  = out_mean_reg;
        out_sd_next    = out_sd_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            rmsd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    count_next = upd_count;
                    sum_next   = upd_sum;
                    sq_next    = upd_sq;
                    err_next   = upd_err;
                    mean_next  = '0;
                    sd_next    = '0;
                    if (upd_count == '0)
                    begin
                        state_next = rmsd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        // mean = (S << F) / n, dividend left-aligned
                        acc_next   = '0;
                        q_next     = '0;
                        ovf_next   = 1'b0;
                        b_next     = BW'(upd_sum) << (BW - SUM_BITS);
                        d_next     = RW'(upd_count);
                        cnt_next   = CNT_W'(DW_MEAN);
                        state_next = rmsd_pkg::ST_MEAN_DIV;
                    end
                end
            end
            rmsd_pkg::ST_MEAN_DIV:
            begin
                acc_next = div_rem;
                q_next   = q_step;
                ovf_next = ovf_step;
                b_next   = b_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step)
                begin
                    mean_next = (ovf_step || (q_step[QW-1:STAT_W] != '0)) ?
                                STAT_MAX : q_step[STAT_W-1:0];
                    if (count_reg == COUNT_BITS'(1))
                    begin
                        state_next = rmsd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        acc_next   = '0;
                        mc_next    = UW'(sum_reg);
                        mp_next    = sum_reg;
                        cnt_next   = CNT_W'(SUM_BITS);
                        state_next = rmsd_pkg::ST_SS_MUL;
                    end
                end
            end
            rmsd_pkg::ST_SS_MUL:
            begin
                acc_next = mul_acc;
                mc_next  = mc_reg << 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step)
                begin
                    mc_next    = UW'(sq_reg);
                    mp_next    = MPW'(count_reg);
                    cnt_next   = CNT_W'(COUNT_BITS);
                    state_next = rmsd_pkg::ST_NQ_MUL;
                end
            end
            rmsd_pkg::ST_NQ_MUL:
            begin
                acc_next = mul_acc;
                mc_next  = mc_reg << 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step)
                begin
                    if (mul_acc[UW-1])
                    begin
                        // n*Q below S*S: deviation taken as zero
                        state_next = rmsd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        b_next     = BW'(mul_acc[PW-1:0]) << (BW - PW);
                        acc_next   = '0;
                        mc_next    = UW'(count_reg);
                        mp_next    = MPW'(count_reg);
                        cnt_next   = CNT_W'(COUNT_BITS);
                        state_next = rmsd_pkg::ST_NN_MUL;
                    end
                end
            end
            rmsd_pkg::ST_NN_MUL:
            begin
                acc_next = mul_acc;
                mc_next  = mc_reg << 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step)
                begin
                    d_next     = mul_acc[RW-1:0];
                    acc_next   = '0;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = CNT_W'(DW_SD);
                    state_next = rmsd_pkg::ST_SD_DIV;
                end
            end
            rmsd_pkg::ST_SD_DIV:
            begin
                acc_next = div_rem;
                q_next   = q_step;
                ovf_next = ovf_step;
                b_next   = b_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step)
                begin
                    if (ovf_step)
                    begin
                        // variance quotient beyond the root's input range
                        sd_next    = STAT_MAX;
                        state_next = rmsd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        acc_next   = UW'(q_step);
                        mc_next    = '0;
                        b_next     = BW'(1) << (QW - 2);
                        cnt_next   = CNT_W'(QW / 2);
                        state_next = rmsd_pkg::ST_SQRT;
                    end
                end
            end
            rmsd_pkg::ST_SQRT:
            begin
                // res and bit never overlap, so res | bit equals res + bit
                if (au_ge)
                begin
                    acc_next = au_res[UW-1:0];
                end
                mc_next  = root_step;
                b_next   = b_reg >> 2;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step)
                begin
                    sd_next    = root_step[STAT_W-1:0];
                    state_next = rmsd_pkg::ST_FINISH;
                end
            end
            rmsd_pkg::ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = rmsd_pkg::COUNT_W'(count_reg);
                    out_mean_next  = mean_reg;
                    out_sd_next    = sd_reg;
                    out_err_next   = err_reg;
                    state_next     = rmsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmsd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        mc_reg        <= mc_next;
        mp_reg        <= mp_next;
        b_reg         <= b_next;
        d_reg         <= d_next;
        q_reg         <= q_next;
        ovf_reg       <= ovf_next;
        mean_reg      <= mean_next;
        sd_reg        <= sd_next;
        err_reg       <= err_next;
        out_count_reg <= out_count_next;
        out_mean_reg  <= out_mean_next;
        out_sd_reg    <= out_sd_next;
        out_err_reg   <= out_err_next;
    end

endmodule
